>>> rtl/pcc_pkg.sv
// pcc_pkg: shared widths, pipeline depths, register map and decision constants
// for the calorimeter cell lookup pipeline. No dependencies.
package pcc_pkg;

    // field widths
    localparam int COORD_W = 23;
    localparam int SUM_W   = 24;
    localparam int SQ_W    = 48;
    localparam int CFG_W   = 20;
    localparam int ETA_W   = 20;
    localparam int BIN_W   = 6;

    // register map
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_RHO_OUTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_PRESAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_REFERENCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_FAN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HADRONIC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_TILE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Z_WHEEL_END = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Z_WHEEL_TWO = 3'd7;
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        20'd32320, 20'd58272, 20'd59032, 20'd59832,
        20'd69232, 20'd97440, 20'd81968, 20'd83200
    };

    // eta pipeline depth: square roots, normalisation, divider, squaring, scale
    localparam int SQRT_STAGES = 32;
    localparam int NORM_STAGES = 4;
    localparam int DIV_STAGES  = 30;
    localparam int SQ_STAGES   = 16;
    localparam int ETA_LAT     = SQRT_STAGES + NORM_STAGES + 1 + DIV_STAGES + SQ_STAGES + 2;

    // phi pipeline depth: set-up stage plus cordic iterations
    localparam int CORDIC_ITERS = 15;
    localparam int PHI_LAT      = 1 + CORDIC_ITERS;

    // top level alignment
    localparam int FRONT_STAGES = 3;
    localparam int PHI_DLY      = FRONT_STAGES + ETA_LAT - (1 + PHI_LAT);
    localparam int TOP_LAT      = FRONT_STAGES + ETA_LAT + 2;

    // eta thresholds, 12 fraction bits
    localparam logic [ETA_W-1:0] E10 = 20'd4096;
    localparam logic [ETA_W-1:0] E13 = 20'd5325;
    localparam logic [ETA_W-1:0] E14 = 20'd5734;
    localparam logic [ETA_W-1:0] E15 = 20'd6144;
    localparam logic [ETA_W-1:0] E17 = 20'd6963;
    localparam logic [ETA_W-1:0] E18 = 20'd7373;
    localparam logic [ETA_W-1:0] E29 = 20'd11878;
    localparam logic [ETA_W-1:0] E30 = 20'd12288;
    localparam logic [ETA_W-1:0] E32 = 20'd13107;
    localparam logic [ETA_W-1:0] E33 = 20'd13517;
    localparam logic [ETA_W-1:0] E50 = 20'd20480;
    localparam logic [ETA_W-1:0] E80 = 20'd32768;

    // fixed forward planes, 1/32 mm
    localparam logic [SUM_W-1:0] FC1_START      = 24'd150672;
    localparam logic [SUM_W-1:0] FC2_START_CEIL = 24'd165386;
    localparam logic [SUM_W-1:0] FC3_START_CEIL = 24'd180570;
    localparam logic [SUM_W-1:0] FC3_END_CEIL   = 24'd194724;
    localparam logic [SUM_W-1:0] FRONT_ONE      = 24'd136496;
    localparam logic [SUM_W-1:0] FRONT_TWO      = 24'd147120;

endpackage

>>> rtl/pcc_if.sv
// pcc_if: step and cell channels with valid/ready handshake.
// Depends on pcc_pkg for field widths.
interface pcc_step_if import pcc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    output ready);
endinterface

interface pcc_cell_if import pcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              fallback;
    logic signed [3:0] subdet;
    logic [1:0]        cell_type;
    logic [1:0]        sampling;
    logic [2:0]        region;
    logic [BIN_W-1:0]  eta_bin;
    logic [BIN_W-1:0]  phi_bin;

    modport source (output valid, fallback, subdet, cell_type, sampling, region,
                    eta_bin, phi_bin, input ready);
    modport sink   (input valid, fallback, subdet, cell_type, sampling, region,
                    eta_bin, phi_bin, output ready);
endinterface

>>> rtl/pcc_eta.sv
// pcc_eta: pipelined |eta| from squared radius, squared magnitude and |z| (square roots, normaliser,
// restoring divider, log2 by repeated squaring, ln2 scale). Depends on pcc_pkg.
module pcc_eta import pcc_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [SQ_W-1:0]  s,
    input  logic [SQ_W-1:0]  t,
    input  logic [SUM_W-1:0] az,
    output logic [ETA_W-1:0] eta
);

    localparam logic [1:0] OVR_NONE = 2'd0;
    localparam logic [1:0] OVR_ZERO = 2'd1;
    localparam logic [1:0] OVR_SAT  = 2'd2;
    localparam logic [ETA_W-1:0] ETA_SAT_VALUE = 20'hFFFFF;
    localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int E_DLY = DIV_STAGES + 1 + SQ_STAGES;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_st_t;

    function automatic sqrt_st_t sqrt_step(sqrt_st_t a, logic [63:0] b);
        sqrt_st_t    o;
        logic [64:0] trial;
        trial = {1'b0, a.r} + {1'b0, b};
        if ({1'b0, a.v} >= trial)
        begin
            o.v = a.v - trial[63:0];
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic logic [4:0] lead_one(logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
        return p;
    endfunction

    // mantissa renormalisation after a squaring: top bit goes to the log
    function automatic logic [30:0] sq_norm(logic [61:0] p);
        return p[61] ? p[61:31] : p[60:30];
    endfunction

    // square root stages for rho and magnitude
    sqrt_st_t         rs_reg  [SQRT_STAGES];
    sqrt_st_t         mg_reg  [SQRT_STAGES];
    logic [SUM_W-1:0] az_reg  [SQRT_STAGES];
    logic [1:0]       ovr_reg [ETA_LAT-1];
    logic [1:0]       ovr_next;

    always_comb
    begin
        if (s != '0)
            ovr_next = OVR_NONE;
        else if (az == '0)
            ovr_next = OVR_ZERO;
        else
            ovr_next = OVR_SAT;
    end

    genvar i;
    for (i = 0; i < SQRT_STAGES; i++)
    begin : g_sqrt
        if (i == 0)
        begin : g_first
            sqrt_st_t rs0, mg0;
            assign rs0 = '{v: {2'b0, s, 14'b0}, r: 64'd0};
            assign mg0 = '{v: {2'b0, t, 14'b0}, r: 64'd0};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rs_reg[0] <= sqrt_step(rs0, SQRT_TOP);
                    mg_reg[0] <= sqrt_step(mg0, SQRT_TOP);
                    az_reg[0] <= az;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rs_reg[i] <= sqrt_step(rs_reg[i-1], SQRT_TOP >> (2 * i));
                    mg_reg[i] <= sqrt_step(mg_reg[i-1], SQRT_TOP >> (2 * i));
                    az_reg[i] <= az_reg[i-1];
                end
            end
        end
    end

    // special case code travels alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovr_reg[0] <= ovr_next;
            for (int j = 1; j < ETA_LAT - 1; j++)
                ovr_reg[j] <= ovr_reg[j-1];
        end
    end

    // normalisation: find e with d<<e <= n < d<<(e+1)
    logic [31:0] n1_n_reg, n1_d_reg;
    logic [31:0] n2_n_reg, n2_d_reg;
    logic [4:0]  n2_pn_reg, n2_pd_reg;
    logic [31:0] n3_n_reg, n3_ds_reg;
    logic [4:0]  n3_k_reg;
    logic [31:0] n4_n_reg, n4_dn_reg;
    logic [4:0]  n4_e_reg;
    logic [4:0]  k_next;

    assign k_next = n2_pn_reg - n2_pd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_n_reg  <= {1'b0, az_reg[SQRT_STAGES-1], 7'b0}
                         + mg_reg[SQRT_STAGES-1].r[31:0];
            n1_d_reg  <= rs_reg[SQRT_STAGES-1].r[31:0];
            n2_n_reg  <= n1_n_reg;
            n2_d_reg  <= n1_d_reg;
            n2_pn_reg <= lead_one(n1_n_reg);
            n2_pd_reg <= lead_one(n1_d_reg);
            n3_n_reg  <= n2_n_reg;
            n3_k_reg  <= k_next;
            n3_ds_reg <= n2_d_reg << k_next;
            n4_n_reg  <= n3_n_reg;
            if (n3_ds_reg > n3_n_reg)
            begin
                n4_dn_reg <= n3_ds_reg >> 1;
                n4_e_reg  <= n3_k_reg - 5'd1;
            end
            else
            begin
                n4_dn_reg <= n3_ds_reg;
                n4_e_reg  <= n3_k_reg;
            end
        end
    end

    // restoring divider, one quotient bit a stage
    logic [32:0] rem_reg [DIV_STAGES+1];
    logic [30:0] q_reg   [DIV_STAGES+1];
    logic [31:0] dv_reg  [DIV_STAGES+1];
    logic [4:0]  e_reg   [E_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, n4_n_reg - n4_dn_reg};
            q_reg[0]   <= 31'd1;
            dv_reg[0]  <= n4_dn_reg;
            e_reg[0]   <= n4_e_reg;
            for (int j = 1; j < E_DLY; j++)
                e_reg[j] <= e_reg[j-1];
        end
    end

    for (i = 1; i <= DIV_STAGES; i++)
    begin : g_div
        logic [32:0] r2;
        logic        ge;
        assign r2 = {rem_reg[i-1][31:0], 1'b0};
        assign ge = r2 >= {1'b0, dv_reg[i-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? r2 - {1'b0, dv_reg[i-1]} : r2;
                q_reg[i]   <= {q_reg[i-1][29:0], ge};
                dv_reg[i]  <= dv_reg[i-1];
            end
        end
    end

    // log2 fraction by repeated squaring, a register after each product
    logic [61:0] p_reg    [SQ_STAGES];
    logic [15:0] bits_reg [SQ_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]    <= q_reg[DIV_STAGES] * q_reg[DIV_STAGES];
            bits_reg[0] <= 16'd0;
        end
    end

    for (i = 1; i < SQ_STAGES; i++)
    begin : g_sq
        logic [30:0] y;
        assign y = sq_norm(p_reg[i-1]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i]    <= y * y;
                bits_reg[i] <= bits_reg[i-1]
                               | (16'(p_reg[i-1][61]) << (SQ_STAGES - i));
            end
        end
    end

    // ln2 scale and special cases
    logic [52:0]      ln_prod_reg;
    logic [ETA_W-1:0] eta_reg;
    logic [20:0]      log2_val;

    assign log2_val = {e_reg[E_DLY-1], bits_reg[SQ_STAGES-1] | 16'(p_reg[SQ_STAGES-1][61])};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_prod_reg <= log2_val * LN2_Q32;
            case (ovr_reg[ETA_LAT-2])
                OVR_ZERO: eta_reg <= '0;
                OVR_SAT:  eta_reg <= ETA_SAT_VALUE;
                default:  eta_reg <= {3'b0, ln_prod_reg[52:36]};
            endcase
        end
    end

    assign eta = eta_reg;

endmodule

>>> rtl/pcc_phi.sv
// pcc_phi: pipelined cordic vectoring, azimuth of the midpoint in 2*pi/65536
// units, giving the top six bits. Depends on pcc_pkg.
module pcc_phi import pcc_pkg::*; (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] x,
    input  logic signed [SUM_W-1:0] y,
    output logic [BIN_W-1:0]        phi_bin
);

    localparam int CW = 36;

    function automatic logic [15:0] atan_units(int idx);
        case (idx)
            0:       return 16'd8192;
            1:       return 16'd4836;
            2:       return 16'd2555;
            3:       return 16'd1297;
            4:       return 16'd651;
            5:       return 16'd326;
            6:       return 16'd163;
            7:       return 16'd81;
            8:       return 16'd41;
            9:       return 16'd20;
            10:      return 16'd10;
            11:      return 16'd5;
            12:      return 16'd3;
            13:      return 16'd1;
            14:      return 16'd1;
            default: return 16'd0;
        endcase
    endfunction

    logic signed [CW-1:0] cx_reg  [PHI_LAT];
    logic signed [CW-1:0] cy_reg  [PHI_LAT];
    logic [15:0]          ang_reg [PHI_LAT];
    logic                 yz_reg  [PHI_LAT];

    // set-up: left half plane folded over, axis case frozen
    logic signed [SUM_W:0] xf, yf;

    always_comb
    begin
        if (x < 0)
        begin
            xf = -(SUM_W+1)'(x);
            yf = -(SUM_W+1)'(y);
        end
        else
        begin
            xf = (SUM_W+1)'(x);
            yf = (SUM_W+1)'(y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]  <= CW'(xf) <<< 8;
            cy_reg[0]  <= CW'(yf) <<< 8;
            ang_reg[0] <= (x < 0) ? 16'd32768 : 16'd0;
            yz_reg[0]  <= (y == '0);
        end
    end

    // one micro-rotation a stage
    genvar i;
    for (i = 1; i < PHI_LAT; i++)
    begin : g_rot
        logic signed [CW-1:0] xs, ys;
        assign xs = cx_reg[i-1] >>> (i - 1);
        assign ys = cy_reg[i-1] >>> (i - 1);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                yz_reg[i] <= yz_reg[i-1];
                if (yz_reg[i-1])
                begin
                    cx_reg[i]  <= cx_reg[i-1];
                    cy_reg[i]  <= cy_reg[i-1];
                    ang_reg[i] <= ang_reg[i-1];
                end
                else if (cy_reg[i-1] > 0)
                begin
                    cx_reg[i]  <= cx_reg[i-1] + ys;
                    cy_reg[i]  <= cy_reg[i-1] - xs;
                    ang_reg[i] <= ang_reg[i-1] + atan_units(i - 1);
                end
                else
                begin
                    cx_reg[i]  <= cx_reg[i-1] - ys;
                    cy_reg[i]  <= cy_reg[i-1] + xs;
                    ang_reg[i] <= ang_reg[i-1] - atan_units(i - 1);
                end
            end
        end
    end

    assign phi_bin = ang_reg[PHI_LAT-1][15:10];

endmodule

>>> rtl/point_to_calorimeter_cell_id.sv
// point_to_calorimeter_cell_id: top level, step midpoint to calorimeter cell id.
// Depends on pcc_pkg, pcc_if, pcc_eta and pcc_phi.
//
// One step item can be accepted every clock cycle unless the pipeline is
// stalled. The pipeline holds three front stages for the coordinate sums,
// the squares and the outer radius test, the eta chain of two bit-serial
// square roots of 32 stages, four normalisation stages, a 31 stage
// restoring divider, 16 squaring stages for the log, a scaling stage and a
// special-case stage, followed by two decision stages. All stages stall
// together when the output item is not taken, so the input is held off while
// a result waits. The boundary registers take effect for items accepted after
// the write; write them only when the pipeline is empty.
module point_to_calorimeter_cell_id import pcc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    pcc_step_if.sink             step_in,
    pcc_cell_if.source           cell_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef struct packed {
        logic             zpos;
        logic [SUM_W-1:0] az;
        logic             rho_out;
    } side_t;

    // configuration registers
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    logic [41:0]      limsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_REGS; j++)
                cfg_reg[j] <= CFG_RESET[j];
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        limsq_reg <= {cfg_reg[REG_RHO_OUTER], 1'b0} * {cfg_reg[REG_RHO_OUTER], 1'b0};
    end

    // pipeline advance and valid bits
    logic               adv;
    logic [TOP_LAT-1:0] valid_reg;

    assign adv           = !valid_reg[TOP_LAT-1] || cell_out.ready;
    assign step_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[TOP_LAT-2:0], step_in.valid};
    end

    // stage a: coordinate sums (midpoint in 1/32 mm)
    logic signed [SUM_W-1:0] xs_a_reg, ys_a_reg, zs_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xs_a_reg <= SUM_W'(step_in.start_x) + SUM_W'(step_in.end_x);
            ys_a_reg <= SUM_W'(step_in.start_y) + SUM_W'(step_in.end_y);
            zs_a_reg <= SUM_W'(step_in.start_z) + SUM_W'(step_in.end_z);
        end
    end

    // stage b: squares and |z|
    logic signed [SQ_W-1:0] xx_full, yy_full, zz_full;
    logic [SQ_W-1:0]        xx_b_reg, yy_b_reg, zz_b_reg;
    logic [SUM_W-1:0]       az_b_reg;
    logic                   zpos_b_reg;

    assign xx_full = xs_a_reg * xs_a_reg;
    assign yy_full = ys_a_reg * ys_a_reg;
    assign zz_full = zs_a_reg * zs_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_b_reg   <= xx_full;
            yy_b_reg   <= yy_full;
            zz_b_reg   <= zz_full;
            az_b_reg   <= (zs_a_reg < 0) ? -zs_a_reg : zs_a_reg;
            zpos_b_reg <= (zs_a_reg > 0);
        end
    end

    // stage c: rho squared, magnitude squared, outer radius test
    logic [SQ_W-1:0] s_c_reg, t_c_reg, s_next;
    side_t           side_c_reg;

    assign s_next = xx_b_reg + yy_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_c_reg            <= s_next;
            t_c_reg            <= xx_b_reg + yy_b_reg + zz_b_reg;
            side_c_reg.zpos    <= zpos_b_reg;
            side_c_reg.az      <= az_b_reg;
            side_c_reg.rho_out <= s_next > {6'b0, limsq_reg};
        end
    end

    // eta and phi units
    logic [ETA_W-1:0] eta;
    logic [BIN_W-1:0] phi_unit;

    pcc_eta u_eta (
        .clk (clk),
        .en  (adv),
        .s   (s_c_reg),
        .t   (t_c_reg),
        .az  (side_c_reg.az),
        .eta (eta)
    );

    pcc_phi u_phi (
        .clk     (clk),
        .en      (adv),
        .x       (xs_a_reg),
        .y       (ys_a_reg),
        .phi_bin (phi_unit)
    );

    // alignment lines to the eta result
    side_t            side_reg [ETA_LAT];
    logic [BIN_W-1:0] phi_reg  [PHI_DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_c_reg;
            for (int j = 1; j < ETA_LAT; j++)
                side_reg[j] <= side_reg[j-1];
            phi_reg[0] <= phi_unit;
            for (int j = 1; j < PHI_DLY; j++)
                phi_reg[j] <= phi_reg[j-1];
        end
    end

    // decision tree
    side_t               sd;
    logic [SUM_W-1:0]    zr1, zr2, zr3, zr4, zr5, zr6, zr7;
    logic                d_found, d_zero, d_clamp, d_mul5, d_phi0, d_fwd;
    logic [1:0]          d_type, d_samp;
    logic [2:0]          d_region;
    logic [ETA_W-1:0]    d_off;

    assign sd  = side_reg[ETA_LAT-1];
    assign zr1 = {3'b0, cfg_reg[REG_Z_PRESAMPLE], 1'b0};
    assign zr2 = {3'b0, cfg_reg[REG_Z_REFERENCE], 1'b0};
    assign zr3 = {3'b0, cfg_reg[REG_Z_FAN], 1'b0};
    assign zr4 = {3'b0, cfg_reg[REG_Z_HADRONIC], 1'b0};
    assign zr5 = {3'b0, cfg_reg[REG_Z_TILE], 1'b0};
    assign zr6 = {3'b0, cfg_reg[REG_Z_WHEEL_END], 1'b0};
    assign zr7 = {3'b0, cfg_reg[REG_Z_WHEEL_TWO], 1'b0};

    always_comb
    begin
        d_found  = 1'b1;
        d_zero   = 1'b0;
        d_clamp  = 1'b0;
        d_mul5   = 1'b0;
        d_phi0   = 1'b0;
        d_fwd    = 1'b0;
        d_type   = 2'd1;
        d_samp   = 2'd0;
        d_region = 3'd0;
        d_off    = '0;
        if (eta < E14)
        begin
            d_samp = 2'd2; d_region = 3'd5; d_off = E10;
        end
        else if (eta < E15 || (sd.rho_out && eta < E17))
        begin
            if (sd.az < zr2)
            begin
                d_samp = 2'd1; d_region = 3'd6; d_off = E13;
            end
            else
            begin
                d_samp = 2'd2; d_region = 3'd5; d_off = E10;
            end
        end
        else if (eta < E18 && sd.az < zr1)
        begin
            d_samp = 2'd1; d_region = 3'd5; d_off = E15;
        end
        else if (eta < E32 && sd.az < zr3)
        begin
            d_samp = 2'd1; d_region = 3'd6; d_off = E13;
        end
        else if (eta < E32 && sd.az < zr4)
        begin
            d_samp = 2'd2; d_region = 3'd3; d_off = E15;
        end
        else if (eta >= E29 && eta < E50 && sd.az < FC1_START)
        begin
            d_clamp = 1'b1;
            if (sd.az < FRONT_ONE)
            begin
                d_samp = 2'd1; d_region = 3'd7; d_off = E32;
            end
            else if (sd.az < FRONT_TWO)
            begin
                d_type = 2'd2; d_samp = 2'd0; d_region = 3'd5; d_off = E30;
            end
            else
            begin
                d_type = 2'd2; d_samp = 2'd1; d_region = 3'd5; d_off = E30;
            end
        end
        else if (eta < E17 && sd.az > zr5)
        begin
            d_fwd = 1'b1; d_samp = 2'd0; d_region = 3'd4;
        end
        else if (eta > E29 && eta < E33 && sd.az > FC1_START && sd.az < FC3_END_CEIL)
        begin
            d_type = 2'd2; d_region = 3'd4; d_zero = 1'b1;
            if (sd.az < FC2_START_CEIL)
                d_samp = 2'd1;
            else if (sd.az < FC3_START_CEIL)
                d_samp = 2'd2;
            else
                d_samp = 2'd3;
        end
        else if (eta < E50 && eta >= E17)
        begin
            d_samp = 2'd3; d_region = 3'd0; d_off = E17;
        end
        else if (eta >= E50 && eta < E80)
        begin
            d_samp = 2'd3; d_region = 3'd1; d_off = E50; d_mul5 = 1'b1;
        end
        else if (eta > E80)
        begin
            d_samp = 2'd3; d_region = 3'd2; d_zero = 1'b1; d_phi0 = 1'b1;
        end
        else if (sd.az > zr6 && sd.az < zr7)
        begin
            d_samp = 2'd2; d_region = 3'd4; d_off = E15;
        end
        else
        begin
            d_found = 1'b0;
        end
    end

    // stage r1: branch result and eta offset
    logic                   r1_found_reg, r1_zero_reg, r1_clamp_reg, r1_mul5_reg;
    logic signed [ETA_W:0]  r1_diff_reg;
    logic signed [3:0]      r1_subdet_reg;
    logic [1:0]             r1_type_reg, r1_samp_reg;
    logic [2:0]             r1_region_reg;
    logic [BIN_W-1:0]       r1_phi_reg;
    logic signed [3:0]      subdet_next;

    always_comb
    begin
        if (d_fwd)
            subdet_next = sd.zpos ? 4'sd5 : -4'sd5;
        else
            subdet_next = sd.zpos ? 4'sd4 : -4'sd4;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_found_reg  <= d_found;
            r1_zero_reg   <= d_zero;
            r1_clamp_reg  <= d_clamp;
            r1_mul5_reg   <= d_mul5;
            r1_diff_reg   <= $signed({1'b0, eta}) - $signed({1'b0, d_off});
            r1_subdet_reg <= subdet_next;
            r1_type_reg   <= d_type;
            r1_samp_reg   <= d_samp;
            r1_region_reg <= d_region;
            r1_phi_reg    <= d_phi0 ? '0 : phi_reg[PHI_DLY-1];
        end
    end

    // stage r2: eta bin, fallback and output register
    logic [ETA_W-1:0] mag;
    logic [23:0]      scaled;
    logic [11:0]      bin_mag;
    logic             bin_neg, fb;
    logic [BIN_W-1:0] bin_sat;

    logic              fallback_reg;
    logic signed [3:0] subdet_reg;
    logic [1:0]        type_reg, samp_reg;
    logic [2:0]        region_reg;
    logic [BIN_W-1:0]  eta_bin_reg, phi_bin_reg;

    always_comb
    begin
        mag     = r1_diff_reg[ETA_W] ? ETA_W'(-r1_diff_reg) : r1_diff_reg[ETA_W-1:0];
        scaled  = r1_mul5_reg ? ({4'b0, mag} << 2) + {4'b0, mag}
                              : ({4'b0, mag} << 3) + ({4'b0, mag} << 1);
        bin_mag = scaled[23:12];
        bin_neg = r1_diff_reg[ETA_W] && (bin_mag != '0) && !r1_zero_reg && !r1_clamp_reg;
        if (r1_zero_reg || (r1_clamp_reg && r1_diff_reg[ETA_W]))
            bin_sat = '0;
        else if (bin_mag > 12'd63)
            bin_sat = 6'd63;
        else
            bin_sat = bin_mag[BIN_W-1:0];
        fb = !r1_found_reg || bin_neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fallback_reg <= fb;
            subdet_reg   <= fb ? '0 : r1_subdet_reg;
            type_reg     <= fb ? '0 : r1_type_reg;
            samp_reg     <= fb ? '0 : r1_samp_reg;
            region_reg   <= fb ? '0 : r1_region_reg;
            eta_bin_reg  <= fb ? '0 : bin_sat;
            phi_bin_reg  <= fb ? '0 : r1_phi_reg;
        end
    end

    assign cell_out.valid     = valid_reg[TOP_LAT-1];
    assign cell_out.fallback  = fallback_reg;
    assign cell_out.subdet    = subdet_reg;
    assign cell_out.cell_type = type_reg;
    assign cell_out.sampling  = samp_reg;
    assign cell_out.region    = region_reg;
    assign cell_out.eta_bin   = eta_bin_reg;
    assign cell_out.phi_bin   = phi_bin_reg;

`ifndef NO_ASSERTIONS
    // a stall freezes the valid pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // a fallback item carries an all-zero identifier
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_out.valid && cell_out.fallback |->
            cell_out.subdet == 4'sd0 && cell_out.cell_type == 2'd0 &&
            cell_out.eta_bin == '0 && cell_out.phi_bin == '0)
        else $error("fallback item with non-zero fields");

    // a found cell has a legal subdetector and type
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_out.valid && !cell_out.fallback |->
            (cell_out.subdet == 4'sd4 || cell_out.subdet == -4'sd4 ||
             cell_out.subdet == 4'sd5 || cell_out.subdet == -4'sd5) &&
            (cell_out.cell_type == 2'd1 || cell_out.cell_type == 2'd2))
        else $error("illegal subdetector or cell type");

    // a taken item with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_out.valid && cell_out.ready && !valid_reg[TOP_LAT-2] |=> !cell_out.valid)
        else $error("output item repeated");
`endif

endmodule

>>> bench/tb_ifs.sv
// tb_ifs: no testbench-only interfaces are needed here; the channel interfaces
// come from rtl/pcc_if.sv, which depends on pcc_pkg.
package tb_pcc_types;
    import pcc_pkg::*;

    // one step item, six coordinates
    typedef struct {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
    } step_t;

    // one cell item
    typedef struct {
        logic              fallback;
        logic signed [3:0] subdet;
        logic [1:0]        cell_type;
        logic [1:0]        sampling;
        logic [2:0]        region;
        logic [BIN_W-1:0]  eta_bin;
        logic [BIN_W-1:0]  phi_bin;
    } cell_t;
endpackage

>>> bench/tb_top.sv
// tb_top: self-checking bench for point_to_calorimeter_cell_id.
// Depends on pcc_pkg, pcc_if, tb_pcc_types and the block's RTL; predicts
// cell items from the step midpoint, takes those of typed directed rows from the table, and compares field by field.
module tb_top import pcc_pkg::*, tb_pcc_types::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LN2_Q32  = 64'd2977044472;
    localparam longint ETA_FULL = 64'hFFFFF;
    localparam longint LIMIT_NS = 64'd5_000_000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PHASE_ITEMS = 100;
    localparam logic [15:0] ATAN_UNITS [15] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
        REG_RHO_OUTER, REG_Z_PRESAMPLE, REG_Z_REFERENCE, REG_Z_FAN,
        REG_Z_HADRONIC, REG_Z_TILE, REG_Z_WHEEL_END, REG_Z_WHEEL_TWO
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pcc_step_if step_ch ();
    pcc_cell_if cell_ch ();

    point_to_calorimeter_cell_id dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_in   (step_ch.sink),
        .cell_out  (cell_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // boundary registers as the bench believes them
    logic [CFG_W-1:0] bounds [NUM_REGS];
    cell_t pending_cells [$];
    int    mismatches;
    int    src_idle;
    int    snk_idle;
    bit    hold_req;
    bit    hold_taken;

    // directed table row
    typedef struct {
        step_t st;
        bit    typed;
        cell_t want_cell;
    } row_t;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS * 1ns);
        $display("point_to_calorimeter_cell_id regression: fail");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // floor square root
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // |eta| in Q12 from rho squared and |z|, both in 1/32 mm
    function automatic longint eta_fixed(input longint unsigned s, input longint unsigned az);
        longint unsigned d;
        longint unsigned n;
        longint unsigned y;
        longint unsigned l;
        int e;
        if (s == 0)
            return (az == 0) ? 0 : ETA_FULL;
        d = root_floor(s << 14);
        n = (az << 7) + root_floor((s + az * az) << 14);
        e = 0;
        while ((d << (e + 1)) <= n)
            e++;
        y = (n << 30) / (d << e);
        l = longint'(e) << 16;
        for (int k = 15; k >= 0; k--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                l |= 64'd1 << k;
                y >>= 1;
            end
        end
        return longint'((l * LN2_Q32) >> 36);
    endfunction

    // azimuth in units of 2*pi/65536
    function automatic logic [15:0] phi_angle(input longint x, input longint y);
        logic [15:0] ang;
        longint xs;
        longint ys;
        ang = 16'd0;
        if (y == 0)
            return (x < 0) ? 16'd32768 : 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 16'd32768;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < 15; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                ang += ATAN_UNITS[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                ang -= ATAN_UNITS[i];
            end
        end
        return ang;
    endfunction

    // bin truncated toward zero
    function automatic longint eta_bin_of(input longint d, input longint mul);
        if (d >= 0)
            return (d * mul) >>> 12;
        return -(((-d) * mul) >>> 12);
    endfunction

    // decision tree on the step midpoint
    function automatic cell_t cell_lookup(input step_t st);
        cell_t  c;
        longint xs, ys, zs, az, s, lim, eq, sd, ty, sa, rg, eb, pb;
        bit     rho_out, found;
        longint zr [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
            zr[i] = longint'(bounds[i]) * 2;
        xs = longint'(st.sx) + longint'(st.ex);
        ys = longint'(st.sy) + longint'(st.ey);
        zs = longint'(st.sz) + longint'(st.ez);
        az = (zs < 0) ? -zs : zs;
        s = xs * xs + ys * ys;
        lim = zr[REG_RHO_OUTER];
        rho_out = s > lim * lim;
        eq = eta_fixed(s, az);
        sd = (zs > 0) ? 4 : -4;
        ty = 1; sa = 0; rg = 0; eb = 0;
        pb = longint'(phi_angle(xs, ys) >> 10);
        found = 1'b1;
        if (eq < E14)
        begin
            sa = 2; rg = 5; eb = eta_bin_of(eq - E10, 10);
        end
        else if (eq < E15 || (rho_out && eq < E17))
        begin
            if (az < zr[REG_Z_REFERENCE])
            begin
                sa = 1; rg = 6; eb = eta_bin_of(eq - E13, 10);
            end
            else
            begin
                sa = 2; rg = 5; eb = eta_bin_of(eq - E10, 10);
            end
        end
        else if (eq < E18 && az < zr[REG_Z_PRESAMPLE])
        begin
            sa = 1; rg = 5; eb = eta_bin_of(eq - E15, 10);
        end
        else if (eq < E32 && az < zr[REG_Z_FAN])
        begin
            sa = 1; rg = 6; eb = eta_bin_of(eq - E13, 10);
        end
        else if (eq < E32 && az < zr[REG_Z_HADRONIC])
        begin
            sa = 2; rg = 3; eb = eta_bin_of(eq - E15, 10);
        end
        else if (eq >= E29 && eq < E50 && az < FC1_START)
        begin
            if (az < FRONT_ONE)
            begin
                sa = 1; rg = 7; eb = eta_bin_of(eq - E32, 10);
            end
            else if (az < FRONT_TWO)
            begin
                ty = 2; sa = 0; rg = 5; eb = eta_bin_of(eq - E30, 10);
            end
            else
            begin
                ty = 2; sa = 1; rg = 5; eb = eta_bin_of(eq - E30, 10);
            end
            if (eb < 0)
                eb = 0;
        end
        else if (eq < E17 && az > zr[REG_Z_TILE])
        begin
            sd = (zs > 0) ? 5 : -5; sa = 0; rg = 4; eb = eta_bin_of(eq, 10);
        end
        else if (eq > E29 && eq < E33 && az > FC1_START && az < FC3_END_CEIL)
        begin
            ty = 2; rg = 4; eb = 0;
            if (az < FC2_START_CEIL)
                sa = 1;
            else if (az < FC3_START_CEIL)
                sa = 2;
            else
                sa = 3;
        end
        else if (eq < E50 && eq >= E17)
        begin
            sa = 3; rg = 0; eb = eta_bin_of(eq - E17, 10);
        end
        else if (eq >= E50 && eq < E80)
        begin
            sa = 3; rg = 1; eb = eta_bin_of(eq - E50, 5);
        end
        else if (eq > E80)
        begin
            sa = 3; rg = 2; eb = 0; pb = 0;
        end
        else if (az > zr[REG_Z_WHEEL_END] && az < zr[REG_Z_WHEEL_TWO])
        begin
            sa = 2; rg = 4; eb = eta_bin_of(eq - E15, 10);
        end
        else
            found = 1'b0;
        c = '{default: '0};
        if (!found || eb < 0)
        begin
            c.fallback = 1'b1;
            return c;
        end
        if (eb > 63)
            eb = 63;
        c.subdet = sd[3:0];
        c.cell_type = ty[1:0];
        c.sampling = sa[1:0];
        c.region = rg[2:0];
        c.eta_bin = eb[5:0];
        c.phi_bin = pb[5:0];
        return c;
    endfunction

    // register write, then drop the enable
    task automatic load_bounds(input logic [CFG_W-1:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= vals[i];
            bounds[REG_ORDER[i]] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one step item and wait for it to be taken
    task automatic send_step(input step_t st, input bit typed, input cell_t want);
        while ($urandom_range(0, 99) < src_idle)
        begin
            step_ch.valid <= 1'b0;
            @(posedge clk);
        end
        step_ch.valid <= 1'b1;
        step_ch.start_x <= st.sx;
        step_ch.start_y <= st.sy;
        step_ch.start_z <= st.sz;
        step_ch.end_x <= st.ex;
        step_ch.end_y <= st.ey;
        step_ch.end_z <= st.ez;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        pending_cells = {pending_cells, typed ? want : cell_lookup(st)};
    endtask

    // split a midpoint sum into start and end coordinates
    function automatic void split_sum(input longint t, output logic signed [COORD_W-1:0] a,
                                      output logic signed [COORD_W-1:0] b);
        longint h;
        h = (t >>> 1) + longint'($urandom_range(0, 2000)) - 1000;
        a = h[COORD_W-1:0];
        b = COORD_W'(t - h);
    endfunction

    // midpoint aimed at the calorimeter, random direction
    function automatic step_t aimed_step();
        step_t  st;
        longint az, r, x, y, z;
        if ($urandom_range(0, 9) < 8)
            az = $urandom_range(0, 220000);
        else
            az = $urandom_range(0, 8380000);
        r = (az >> $urandom_range(0, 16)) + $urandom_range(0, 15);
        x = longint'($urandom_range(0, 2 * r)) - r;
        y = longint'($urandom_range(0, 2 * r)) - r;
        z = $urandom_range(0, 1) ? az : -az;
        split_sum(x, st.sx, st.ex);
        split_sum(y, st.sy, st.ey);
        split_sum(z, st.sz, st.ez);
        return st;
    endfunction

    function automatic step_t noise_step();
        step_t st;
        st.sx = COORD_W'($urandom); st.sy = COORD_W'($urandom); st.sz = COORD_W'($urandom);
        st.ex = COORD_W'($urandom); st.ey = COORD_W'($urandom); st.ez = COORD_W'($urandom);
        return st;
    endfunction

    // receiver: random ready, long hold on request, checks each item
    initial
    begin
        int    hold_left;
        cell_t want;
        hold_left = 0;
        cell_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && cell_ch.valid && cell_ch.ready)
            begin
                if (pending_cells.size() == 0)
                    report("unexpected item", 0, 0);
                else
                begin
                    want = pending_cells.pop_front();
                    if (cell_ch.fallback !== want.fallback)
                        report("fallback", cell_ch.fallback, want.fallback);
                    if (cell_ch.subdet !== want.subdet)
                        report("subdet", cell_ch.subdet, want.subdet);
                    if (cell_ch.cell_type !== want.cell_type)
                        report("cell_type", cell_ch.cell_type, want.cell_type);
                    if (cell_ch.sampling !== want.sampling)
                        report("sampling", cell_ch.sampling, want.sampling);
                    if (cell_ch.region !== want.region)
                        report("region", cell_ch.region, want.region);
                    if (cell_ch.eta_bin !== want.eta_bin)
                        report("eta_bin", cell_ch.eta_bin, want.eta_bin);
                    if (cell_ch.phi_bin !== want.phi_bin)
                        report("phi_bin", cell_ch.phi_bin, want.phi_bin);
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cell_ch.ready <= 1'b0;
            end
            else
                cell_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // stimulus
    initial
    begin
        row_t             rows [$];
        row_t             rw;
        cell_t            none;
        logic [CFG_W-1:0] vals [NUM_REGS];
        int               waited;
        mismatches = 0;
        src_idle = 8;
        snk_idle = 56;
        hold_req = 1'b0;
        hold_taken = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        step_ch.valid = 1'b0;
        step_ch.start_x = '0; step_ch.start_y = '0; step_ch.start_z = '0;
        step_ch.end_x = '0; step_ch.end_y = '0; step_ch.end_z = '0;
        for (int i = 0; i < NUM_REGS; i++)
            bounds[i] = CFG_RESET[i];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: origin, both z axes, extremes, axes, branch probes
        none = '{default: '0};
        rw.typed = 1'b1;
        rw.want_cell = none; rw.want_cell.fallback = 1'b1;
        rw.st = '{0, 0, 0, 0, 0, 0};
        rows = {rows, rw};
        rw.want_cell = '{1'b0, 4'sd4, 2'd1, 2'd3, 3'd2, 6'd0, 6'd0};
        rw.st = '{0, 0, 1000, 0, 0, 1000};
        rows = {rows, rw};
        rw.want_cell.subdet = -4'sd4;
        rw.st = '{0, 0, -4194304, 0, 0, -4194304};
        rows = {rows, rw};
        rw.typed = 1'b0;
        rw.st = '{4194303, 4194303, 4194303, 4194303, 4194303, 4194303};
        rows = {rows, rw};
        rw.st = '{-4194304, -4194304, -4194304, -4194304, -4194304, -4194304};
        rows = {rows, rw};
        rw.st = '{4194303, -4194304, 4194303, -4194304, 4194303, -4194304};
        rows = {rows, rw};
        rw.st = '{-30000, 0, 60000, -30000, 0, 60000}; rows = {rows, rw};
        rw.st = '{30000, 0, -60000, 30000, 0, -60000}; rows = {rows, rw};
        rw.st = '{0, -20000, 29000, 0, -20000, 29000}; rows = {rows, rw};
        rw.st = '{16000, 3000, 30000, 16000, 3000, 30000}; rows = {rows, rw};
        rw.st = '{4000, 4000, 59000, 4000, 4000, 59000}; rows = {rows, rw};
        rw.st = '{2000, -1000, 66000, 2000, -1000, 66000}; rows = {rows, rw};
        rw.st = '{-800, 900, 70000, -800, 900, 70000}; rows = {rows, rw};
        rw.st = '{300, 200, 76000, 300, 200, 76000}; rows = {rows, rw};
        rw.st = '{5000, 5000, 99000, 5000, 5000, 99000}; rows = {rows, rw};
        rw.st = '{100, -60, 90000, 100, -60, 90000}; rows = {rows, rw};
        rw.st = '{3, 2, 82500, 3, 2, 82500}; rows = {rows, rw};
        rw.st = '{40000, 10, 1000, 40000, 10, 1000}; rows = {rows, rw};
        rw.st = '{33000, -33000, 20000, 33000, -33000, 20000}; rows = {rows, rw};
        rw.st = '{-1, 1, -85000, -1, 1, -85000}; rows = {rows, rw};
        foreach (rows[i])
            send_step(rows[i].st, rows[i].typed, rows[i].want_cell);

        // phases: settings and idling change only with the pipeline empty
        for (int ph = 0; ph < 5; ph++)
        begin
            step_ch.valid <= 1'b0;
            waited = 0;
            while (pending_cells.size() != 0 && waited < 100000)
            begin
                @(posedge clk);
                waited++;
            end
            case (ph)
                0: for (int i = 0; i < NUM_REGS; i++) vals[i] = CFG_RESET[i];
                2: for (int i = 0; i < NUM_REGS; i++) vals[i] = '0;
                3: for (int i = 0; i < NUM_REGS; i++) vals[i] = '1;
                default:
                    for (int i = 0; i < NUM_REGS; i++)
                        vals[i] = (i == 0) ? CFG_W'($urandom_range(0, 70000))
                                           : CFG_W'($urandom_range(0, 120000));
            endcase
            load_bounds(vals);
            src_idle = (ph % 3 == 0) ? 8 : (ph % 3 == 1) ? 56 : 0;
            snk_idle = (ph % 3 == 0) ? 56 : (ph % 3 == 1) ? 8 : 0;
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_step(($urandom_range(0, 9) < 8) ? aimed_step() : noise_step(), 1'b0,
                          none);
        end
        step_ch.valid <= 1'b0;

        // drain, then watch for stray items
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (TOP_LAT + 20) @(posedge clk);
        if (mismatches == 0)
            $display("point_to_calorimeter_cell_id regression: pass");
        else
            $display("point_to_calorimeter_cell_id regression: fail");
        $finish;
    end
endmodule

>>> point_to_calorimeter_cell_id.f
rtl/pcc_pkg.sv
rtl/pcc_if.sv
rtl/pcc_eta.sv
rtl/pcc_phi.sv
rtl/point_to_calorimeter_cell_id.sv
bench/tb_ifs.sv
bench/tb_top.sv
